FILE: rtl/bfsr_pkg.sv
package bfsr_pkg;

	localparam int PRESS_COUNT_WIDTH_DEF = 16;

	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam int RAMP_WAIT_WIDTH = 12;
	localparam int DCLICK_WIDTH    = 14;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DUTY_TOP    = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEVEL_ZERO  = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEVEL_ONE   = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEVEL_TWO   = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEVEL_THREE = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_LEVEL = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS  = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DCLICK      = 3'd7;

	localparam logic [7:0]              DUTY_TOP_RST    = 8'h2F;
	localparam logic [7:0]              LEVEL_ZERO_RST  = 8'h00;
	localparam logic [7:0]              LEVEL_ONE_RST   = 8'h0C;
	localparam logic [7:0]              LEVEL_TWO_RST   = 8'h1E;
	localparam logic [7:0]              LEVEL_THREE_RST = 8'h2F;
	localparam logic [1:0]              START_LEVEL_RST = 2'd1;
	localparam logic [15:0]             LONG_PRESS_RST  = 16'd50000;
	localparam logic [DCLICK_WIDTH-1:0] DCLICK_RST      = 14'd10000;

	localparam int SHORT_PRESS_TICKS = 500;
	localparam int RESET_PULSE_TICKS = 6250;

	localparam logic [RAMP_WAIT_WIDTH-1:0] WAIT_DOWN = 12'd1250;
	localparam logic [RAMP_WAIT_WIDTH-1:0] WAIT_UP   = 12'd2500;
	localparam logic [RAMP_WAIT_WIDTH-1:0] WAIT_KICK = 12'd1250;

	typedef struct packed {
		logic [7:0]              duty_top;
		logic [7:0]              level_zero;
		logic [7:0]              level_one;
		logic [7:0]              level_two;
		logic [7:0]              level_three;
		logic [1:0]              start_level;
		logic [15:0]             long_press_ticks;
		logic [DCLICK_WIDTH-1:0] doubleclick_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] duty;
		logic       drive_on;
		logic       reset_line;
		logic       save_pulse;
		logic [1:0] save_level;
	} res_t;

	function automatic logic [7:0] level_duty(input cfg_t cfg, input logic [1:0] idx);
		logic [7:0] d;
		case (idx)
			2'd0:    d = cfg.level_zero;
			2'd1:    d = cfg.level_one;
			2'd2:    d = cfg.level_two;
			default: d = cfg.level_three;
		endcase
		return d;
	endfunction

endpackage

FILE: rtl/bfsr_cfg.sv
module bfsr_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bfsr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [bfsr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	output bfsr_pkg::cfg_t                       cfg
);
	import bfsr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_top          <= DUTY_TOP_RST;
			cfg_q.level_zero        <= LEVEL_ZERO_RST;
			cfg_q.level_one         <= LEVEL_ONE_RST;
			cfg_q.level_two         <= LEVEL_TWO_RST;
			cfg_q.level_three       <= LEVEL_THREE_RST;
			cfg_q.start_level       <= START_LEVEL_RST;
			cfg_q.long_press_ticks  <= LONG_PRESS_RST;
			cfg_q.doubleclick_ticks <= DCLICK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DUTY_TOP:    cfg_q.duty_top          <= cfg_data[7:0];
				REG_LEVEL_ZERO:  cfg_q.level_zero        <= cfg_data[7:0];
				REG_LEVEL_ONE:   cfg_q.level_one         <= cfg_data[7:0];
				REG_LEVEL_TWO:   cfg_q.level_two         <= cfg_data[7:0];
				REG_LEVEL_THREE: cfg_q.level_three       <= cfg_data[7:0];
				REG_START_LEVEL: cfg_q.start_level       <= cfg_data[1:0];
				REG_LONG_PRESS:  cfg_q.long_press_ticks  <= cfg_data[15:0];
				REG_DCLICK:      cfg_q.doubleclick_ticks <= cfg_data[DCLICK_WIDTH-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/bfsr_core.sv
module bfsr_core #(
	parameter int PRESS_COUNT_WIDTH = bfsr_pkg::PRESS_COUNT_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           key_low,
	input  bfsr_pkg::cfg_t cfg,
	output bfsr_pkg::res_t res
);
	import bfsr_pkg::*;

	localparam logic [PRESS_COUNT_WIDTH-1:0] SHORT_PC = PRESS_COUNT_WIDTH'(SHORT_PRESS_TICKS);
	localparam logic [PRESS_COUNT_WIDTH-1:0] PULSE_PC = PRESS_COUNT_WIDTH'(RESET_PULSE_TICKS);

	logic [7:0]                   duty_q, target_q;
	logic [1:0]                   level_q;
	logic                         kick_q, press_seen_q, single_q, reset_level_q, started_q;
	logic [RAMP_WAIT_WIDTH-1:0]   ramp_wait_q;
	logic [PRESS_COUNT_WIDTH-1:0] press_count_q;
	logic [DCLICK_WIDTH-1:0]      spw_q;

	logic [7:0]                   duty_d, target_d;
	logic [1:0]                   level_d;
	logic                         kick_d, press_seen_d, single_d, reset_level_d, save_d;
	logic [RAMP_WAIT_WIDTH-1:0]   ramp_wait_d;
	logic [PRESS_COUNT_WIDTH-1:0] press_count_d;
	logic [DCLICK_WIDTH-1:0]      spw_d;

	// values after the first-tick load
	logic [1:0]                   level_a;
	logic [7:0]                   target_a, goal, next_duty;
	logic                         kick_a;
	logic [PRESS_COUNT_WIDTH-1:0] long_pc, pc_inc;
	logic                         is_long;

	always_comb begin
		if (!started_q) begin
			level_a  = cfg.start_level;
			target_a = level_duty(cfg, cfg.start_level);
			kick_a   = level_duty(cfg, cfg.start_level) != 8'd0;
		end else begin
			level_a  = level_q;
			target_a = target_q;
			kick_a   = kick_q;
		end
	end

	assign goal      = kick_a ? cfg.duty_top : target_a;
	assign next_duty = level_duty(cfg, level_a + 2'd1);
	assign long_pc   = PRESS_COUNT_WIDTH'(cfg.long_press_ticks);
	assign pc_inc    = (press_seen_q && !(&press_count_q)) ?
		press_count_q + PRESS_COUNT_WIDTH'(1) : press_count_q;
	assign is_long   = pc_inc > long_pc;

	always_comb begin
		level_d       = level_a;
		target_d      = target_a;
		kick_d        = kick_a;
		duty_d        = duty_q;
		ramp_wait_d   = ramp_wait_q;
		press_seen_d  = press_seen_q;
		press_count_d = pc_inc;
		spw_d         = spw_q;
		single_d      = single_q;
		reset_level_d = reset_level_q;
		save_d        = 1'b0;

		// duty ramp
		if (ramp_wait_q != '0) begin
			ramp_wait_d = ramp_wait_q - RAMP_WAIT_WIDTH'(1);
		end else if (duty_q < goal) begin
			ramp_wait_d = kick_a ? WAIT_KICK : WAIT_UP;
			duty_d      = duty_q + 8'd1;
		end else if (duty_q > goal) begin
			ramp_wait_d = WAIT_DOWN;
			duty_d      = duty_q - 8'd1;
		end else if (kick_a) begin
			kick_d = 1'b0;
		end

		// double press window
		if (spw_q != '0) begin
			spw_d    = spw_q - DCLICK_WIDTH'(1);
			single_d = (spw_q == DCLICK_WIDTH'(1));
		end

		if (key_low) begin
			press_seen_d = 1'b1;
			if (is_long) begin
				reset_level_d = (pc_inc - long_pc) >= PULSE_PC;
			end
		end else begin
			press_seen_d  = 1'b0;
			press_count_d = '0;
			if (is_long) begin
				single_d      = 1'b0;
				reset_level_d = 1'b1;
			end else if (pc_inc > SHORT_PC) begin
				if (spw_d != '0) begin
					spw_d  = '0;
					save_d = 1'b1;
				end else begin
					spw_d = cfg.doubleclick_ticks;
				end
			end else if (single_d) begin
				// a key-high tick without a long or short press completes a pending single press
				single_d = 1'b0;
				level_d  = level_a + 2'd1;
				kick_d   = (target_a == 8'd0) && (duty_d < next_duty);
				target_d = next_duty;
			end
		end
	end

	assign res.duty       = duty_d;
	assign res.drive_on   = duty_d != 8'd0;
	assign res.reset_line = reset_level_d;
	assign res.save_pulse = save_d;
	assign res.save_level = save_d ? level_d : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q        <= '0;
			target_q      <= '0;
			level_q       <= '0;
			kick_q        <= 1'b0;
			ramp_wait_q   <= '0;
			press_count_q <= '0;
			press_seen_q  <= 1'b0;
			spw_q         <= '0;
			single_q      <= 1'b0;
			reset_level_q <= 1'b1;
			started_q     <= 1'b0;
		end else if (step) begin
			duty_q        <= duty_d;
			target_q      <= target_d;
			level_q       <= level_d;
			kick_q        <= kick_d;
			ramp_wait_q   <= ramp_wait_d;
			press_count_q <= press_count_d;
			press_seen_q  <= press_seen_d;
			spw_q         <= spw_d;
			single_q      <= single_d;
			reset_level_q <= reset_level_d;
			started_q     <= 1'b1;
		end
	end

endmodule

FILE: rtl/button_fan_speed_ramp_controller.sv
// Fan speed ramp controller driven by one tick item per PWM period carrying the button
// level. Each accepted tick gives exactly one result item (duty, drive_on, reset_line,
// save_pulse, save_level). A tick is taken every clock cycle while in_stall is low: the
// state update is a single combinational pass from the state registers into an output
// register, backed by a one-entry skid register, so in_stall only rises after out_stall
// has held back two results. Registers may be written through the cfg port at any time
// the block is idle; cfg_ready is always high.
module button_fan_speed_ramp_controller #(
	parameter int PRESS_COUNT_WIDTH = bfsr_pkg::PRESS_COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 key_low,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [7:0]                           duty,
	output logic                                 drive_on,
	output logic                                 reset_line,
	output logic                                 save_pulse,
	output logic [1:0]                           save_level,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bfsr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [bfsr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	import bfsr_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic accept, take;

	bfsr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bfsr_core #(
		.PRESS_COUNT_WIDTH (PRESS_COUNT_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.key_low (key_low),
		.cfg     (cfg),
		.res     (res)
	);

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign take     = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign duty       = out_q.duty;
	assign drive_on   = out_q.drive_on;
	assign reset_line = out_q.reset_line;
	assign save_pulse = out_q.save_pulse;
	assign save_level = out_q.save_level;

endmodule
